/* hw/rtl/triangle_adjacency_builder_unit_assert.svh */
// assertion macros for the triangle adjacency builder
`ifndef TRIANGLE_ADJACENCY_BUILDER_UNIT_ASSERT_SVH
`define TRIANGLE_ADJACENCY_BUILDER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tab_pkg.sv */
package tab_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] vert_a;
        logic [15:0] vert_b;
        logic [15:0] vert_c;
        logic [9:0]  tri_select;
    } t_cmd_item;

    // result item
    typedef struct packed {
        logic [15:0] out_a;
        logic [15:0] adj_ab;
        logic [15:0] out_b;
        logic [15:0] adj_bc;
        logic [15:0] out_c;
        logic [15:0] adj_ca;
        logic [1:0]  status;
    } t_rsp_item;

endpackage

/* hw/rtl/tab_ram.sv */
module tab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/triangle_adjacency_builder_unit.sv */
// Triangle edge adjacency builder.
// Command channel: i_cmd is taken at a clock edge where start is high and
// busy is low. Load stores a triangle (no result unless the store is full,
// then one overflow result in the next cycle). Clear empties the store
// with no result. Read gives exactly one result on o_result, marked by
// o_strobe for one cycle; the receiver cannot hold it off.
// A read of an already built table passes through the request state and
// the output state before the strobe rises (only the request state when the
// index is out of range). The first read after a load or clear rebuilds the
// table first: a clearing pass over the N stored entries, then for each
// triangle i a row fetch and load, a fetch and update per later triangle j,
// and a write-back of row i. The pair loop runs through one triangle RAM
// and one adjacency RAM, each with one read and one write port, and a
// read-modify-write of the later triangle's entry per pair.
// busy stays high for the whole build and read.
// Reset empties the store and marks the table stale; RAM contents are not
// cleared, entries are only read after being written.
module triangle_adjacency_builder_unit #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int VERTEX_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tab_pkg::t_cmd_item   i_cmd,
    output logic                 o_strobe,
    output tab_pkg::t_rsp_item   o_result
);

    import tab_pkg::*;

    localparam int VB  = VERTEX_BITS;
    localparam int AW  = $clog2(MAX_TRIANGLES);
    localparam int CW  = $clog2(MAX_TRIANGLES + 1);
    localparam int SW  = (CW > 10) ? CW : 10;
    localparam int TW  = 3 * VB;
    localparam int EW  = VB + 1;
    localparam int ADW = 3 * EW;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TRIANGLES);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLR     = 3'd1;
    localparam logic [2:0] ST_ROW_RD  = 3'd2;
    localparam logic [2:0] ST_ROW_LD  = 3'd3;
    localparam logic [2:0] ST_PAIR_RD = 3'd4;
    localparam logic [2:0] ST_PAIR_UP = 3'd5;
    localparam logic [2:0] ST_RD_REQ  = 3'd6;
    localparam logic [2:0] ST_RD_OUT  = 3'd7;

    function automatic logic [VB-1:0] to_vb(input logic [15:0] v);
        logic [VB+15:0] t;
        t = {{VB{1'b0}}, v};
        return t[VB-1:0];
    endfunction

    function automatic logic [15:0] to_16(input logic [VB-1:0] v);
        logic [VB+15:0] t;
        t = {16'b0, v};
        return t[15:0];
    endfunction

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_current, n_current;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_j, n_j;
    logic [9:0]     r_sel, n_sel;
    logic [TW-1:0]  r_itri, n_itri;
    logic [ADW-1:0] r_iadj, n_iadj;
    logic           r_strobe, n_strobe;
    t_rsp_item      r_result, n_result;

    logic           tri_we;
    logic [AW-1:0]  tri_waddr;
    logic [TW-1:0]  tri_wdata;
    logic [TW-1:0]  tri_rdata;
    logic           adj_we;
    logic [AW-1:0]  adj_waddr;
    logic [ADW-1:0] adj_wdata;
    logic [ADW-1:0] adj_rdata;
    logic [AW-1:0]  raddr;

    logic [SW-1:0]  sel_ext;
    logic [SW-1:0]  cnt_ext;
    logic [VB-1:0]  v1 [3];
    logic [VB-1:0]  v2 [3];
    logic [ADW-1:0] pair_iadj;
    logic [ADW-1:0] pair_jadj;
    logic           accept;

    tab_ram #(.WIDTH(TW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
        .i_clk   (i_clk),
        .i_we    (tri_we),
        .i_waddr (tri_waddr),
        .i_wdata (tri_wdata),
        .i_raddr (raddr),
        .o_rdata (tri_rdata)
    );

    tab_ram #(.WIDTH(ADW), .DEPTH(MAX_TRIANGLES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (raddr),
        .o_rdata (adj_rdata)
    );

    assign accept  = start && !busy;
    assign sel_ext = SW'(r_sel);
    assign cnt_ext = SW'(r_count);

    // edge compare of triangle i against triangle j, fixed order, last match wins
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v1[k] = r_itri[k*VB +: VB];
            v2[k] = tri_rdata[k*VB +: VB];
        end
        pair_iadj = r_iadj;
        pair_jadj = adj_rdata;
        for (int m = 0; m < 9; m++) begin
            if ((v1[m/3] == v2[m%3] && v1[(m/3+1)%3] == v2[(m%3+1)%3]) ||
                (v1[m/3] == v2[(m%3+1)%3] && v1[(m/3+1)%3] == v2[m%3])) begin
                pair_iadj[(m/3)*EW +: EW] = {1'b1, v2[(m%3+2)%3]};
                pair_jadj[(m%3)*EW +: EW] = {1'b1, v1[(m/3+2)%3]};
            end
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_current = r_current;
        n_i       = r_i;
        n_j       = r_j;
        n_sel     = r_sel;
        n_itri    = r_itri;
        n_iadj    = r_iadj;
        n_strobe  = 1'b0;
        n_result  = r_result;
        tri_we    = 1'b0;
        tri_waddr = r_count[AW-1:0];
        tri_wdata = {to_vb(i_cmd.vert_c), to_vb(i_cmd.vert_b), to_vb(i_cmd.vert_a)};
        adj_we    = 1'b0;
        adj_waddr = r_i[AW-1:0];
        adj_wdata = '0;
        raddr     = r_i[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.command)
                        CMD_LOAD: begin
                            if (r_count == MAX_COUNT) begin
                                n_strobe = 1'b1;
                                n_result = '0;
                                n_result.status = STATUS_OVERFLOW;
                            end else begin
                                tri_we    = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_current = 1'b0;
                            end
                        end
                        CMD_READ: begin
                            n_sel = i_cmd.tri_select;
                            n_i   = '0;
                            n_state = r_current ? ST_RD_REQ : ST_CLR;
                        end
                        CMD_CLEAR: begin
                            n_count   = '0;
                            n_current = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // zero the adjacency entries of the stored triangles
            ST_CLR: begin
                if (r_i < r_count) begin
                    adj_we = 1'b1;
                    n_i    = r_i + 1'b1;
                end else begin
                    n_i     = '0;
                    n_state = ST_ROW_RD;
                end
            end
            // fetch triangle i and its entry
            ST_ROW_RD: begin
                if (r_i < r_count) begin
                    n_state = ST_ROW_LD;
                end else begin
                    n_current = 1'b1;
                    n_state   = ST_RD_REQ;
                end
            end
            ST_ROW_LD: begin
                n_itri  = tri_rdata;
                n_iadj  = adj_rdata;
                n_j     = r_i + 1'b1;
                n_state = ST_PAIR_RD;
            end
            // fetch triangle j, or close row i
            ST_PAIR_RD: begin
                raddr = r_j[AW-1:0];
                if (r_j < r_count) begin
                    n_state = ST_PAIR_UP;
                end else begin
                    adj_we    = 1'b1;
                    adj_wdata = r_iadj;
                    n_i       = r_i + 1'b1;
                    n_state   = ST_ROW_RD;
                end
            end
            // write back entry j, keep entry i in the row register
            ST_PAIR_UP: begin
                adj_we    = 1'b1;
                adj_waddr = r_j[AW-1:0];
                adj_wdata = pair_jadj;
                n_iadj    = pair_iadj;
                n_j       = r_j + 1'b1;
                n_state   = ST_PAIR_RD;
            end
            ST_RD_REQ: begin
                raddr = sel_ext[AW-1:0];
                if (sel_ext >= cnt_ext) begin
                    n_strobe = 1'b1;
                    n_result = '0;
                    n_result.status = STATUS_RANGE;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD_OUT;
                end
            end
            // assemble the result, fall back to own vertices where unmatched
            ST_RD_OUT: begin
                n_strobe = 1'b1;
                n_result.out_a  = to_16(tri_rdata[0*VB +: VB]);
                n_result.out_b  = to_16(tri_rdata[1*VB +: VB]);
                n_result.out_c  = to_16(tri_rdata[2*VB +: VB]);
                n_result.adj_ab = to_16(adj_rdata[0*EW+VB] ? adj_rdata[0*EW +: VB]
                                                          : tri_rdata[2*VB +: VB]);
                n_result.adj_bc = to_16(adj_rdata[1*EW+VB] ? adj_rdata[1*EW +: VB]
                                                          : tri_rdata[0*VB +: VB]);
                n_result.adj_ca = to_16(adj_rdata[2*EW+VB] ? adj_rdata[2*EW +: VB]
                                                          : tri_rdata[1*VB +: VB]);
                n_result.status = STATUS_OK;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_current <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_current <= n_current;
            r_strobe  <= n_strobe;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_sel    <= n_sel;
        r_itri   <= n_itri;
        r_iadj   <= n_iadj;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`include "triangle_adjacency_builder_unit_assert.svh"

    `TAB_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAX_COUNT, "triangle count past capacity")
    `TAB_ASSERT_NEXT(a_overflow_flag, accept && i_cmd.command == CMD_LOAD && r_count == MAX_COUNT,
        o_strobe && o_result.status == STATUS_OVERFLOW, "full load not flagged")
    `TAB_ASSERT_NOW(a_built_before_read, r_state == ST_RD_OUT, r_current, "read of stale table")
    `TAB_ASSERT_NOW(a_pair_order, r_state == ST_PAIR_UP, r_j > r_i && r_j < r_count,
        "pair index out of order")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import tab_pkg::*;

    localparam int CAP = 1024;
    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_cmd_item i_cmd = '0;
    logic o_strobe;
    t_rsp_item o_result;

    // mesh model state
    logic [15:0] mesh_vert [CAP][3];
    logic [15:0] mesh_adj [CAP][3];
    bit mesh_adj_set [CAP][3];
    int unsigned mesh_count = 0;
    bit adjacency_fresh = 1'b0;

    t_rsp_item pending_results[$];
    logic [15:0] vert_pool[16];
    bit failed = 1'b0;
    int unsigned cycle_count = 0;

    triangle_adjacency_builder_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // queue one expected result at the tail
    function automatic void expect_result(t_rsp_item r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // record one neighbour vertex for an edge
    function automatic void mark_edge(int t, int e, logic [15:0] v);
        mesh_adj[t][e] = v;
        mesh_adj_set[t][e] = 1'b1;
    endfunction

    // pairwise edge match over all stored triangles, later matches win
    function automatic void rebuild_adjacency();
        logic [15:0] a1, b1, c1, a2, b2, c2;
        for (int i = 0; i < mesh_count; i++)
            for (int e = 0; e < 3; e++)
                mesh_adj_set[i][e] = 1'b0;
        for (int i = 0; i < mesh_count; i++) begin
            a1 = mesh_vert[i][0]; b1 = mesh_vert[i][1]; c1 = mesh_vert[i][2];
            for (int j = i + 1; j < mesh_count; j++) begin
                a2 = mesh_vert[j][0]; b2 = mesh_vert[j][1]; c2 = mesh_vert[j][2];
                // edge a-b of i
                if ((a1 == a2 && b1 == b2) || (a1 == b2 && b1 == a2)) begin
                    mark_edge(i, 0, c2); mark_edge(j, 0, c1); end
                if ((a1 == b2 && b1 == c2) || (a1 == c2 && b1 == b2)) begin
                    mark_edge(i, 0, a2); mark_edge(j, 1, c1); end
                if ((a1 == c2 && b1 == a2) || (a1 == a2 && b1 == c2)) begin
                    mark_edge(i, 0, b2); mark_edge(j, 2, c1); end
                // edge b-c of i
                if ((b1 == a2 && c1 == b2) || (b1 == b2 && c1 == a2)) begin
                    mark_edge(i, 1, c2); mark_edge(j, 0, a1); end
                if ((b1 == b2 && c1 == c2) || (b1 == c2 && c1 == b2)) begin
                    mark_edge(i, 1, a2); mark_edge(j, 1, a1); end
                if ((b1 == c2 && c1 == a2) || (b1 == a2 && c1 == c2)) begin
                    mark_edge(i, 1, b2); mark_edge(j, 2, a1); end
                // edge c-a of i
                if ((c1 == a2 && a1 == b2) || (c1 == b2 && a1 == a2)) begin
                    mark_edge(i, 2, c2); mark_edge(j, 0, b1); end
                if ((c1 == b2 && a1 == c2) || (c1 == c2 && a1 == b2)) begin
                    mark_edge(i, 2, a2); mark_edge(j, 1, b1); end
                if ((c1 == c2 && a1 == a2) || (c1 == a2 && a1 == c2)) begin
                    mark_edge(i, 2, b2); mark_edge(j, 2, b1); end
            end
        end
        adjacency_fresh = 1'b1;
    endfunction

    // apply one accepted item to the model, queue any result
    function automatic void predict_item(t_cmd_item it);
        t_rsp_item r;
        int s;
        r = '0;
        case (it.command)
            CMD_LOAD: begin
                if (mesh_count >= CAP) begin
                    r.status = STATUS_OVERFLOW;
                    expect_result(r);
                end else begin
                    mesh_vert[mesh_count][0] = it.vert_a;
                    mesh_vert[mesh_count][1] = it.vert_b;
                    mesh_vert[mesh_count][2] = it.vert_c;
                    mesh_count++;
                    adjacency_fresh = 1'b0;
                end
            end
            CMD_READ: begin
                if (!adjacency_fresh) rebuild_adjacency();
                s = int'(it.tri_select);
                if (s >= mesh_count) begin
                    r.status = STATUS_RANGE;
                end else begin
                    r.out_a = mesh_vert[s][0];
                    r.out_b = mesh_vert[s][1];
                    r.out_c = mesh_vert[s][2];
                    r.adj_ab = mesh_adj_set[s][0] ? mesh_adj[s][0] : mesh_vert[s][2];
                    r.adj_bc = mesh_adj_set[s][1] ? mesh_adj[s][1] : mesh_vert[s][0];
                    r.adj_ca = mesh_adj_set[s][2] ? mesh_adj[s][2] : mesh_vert[s][1];
                    r.status = STATUS_OK;
                end
                expect_result(r);
            end
            CMD_CLEAR: begin
                mesh_count = 0;
                adjacency_fresh = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", o_result);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_result.out_a !== want.out_a) begin
                    $error("out_a expected %h actual %h", want.out_a, o_result.out_a);
                    failed = 1'b1;
                end
                if (o_result.adj_ab !== want.adj_ab) begin
                    $error("adj_ab expected %h actual %h", want.adj_ab, o_result.adj_ab);
                    failed = 1'b1;
                end
                if (o_result.out_b !== want.out_b) begin
                    $error("out_b expected %h actual %h", want.out_b, o_result.out_b);
                    failed = 1'b1;
                end
                if (o_result.adj_bc !== want.adj_bc) begin
                    $error("adj_bc expected %h actual %h", want.adj_bc, o_result.adj_bc);
                    failed = 1'b1;
                end
                if (o_result.out_c !== want.out_c) begin
                    $error("out_c expected %h actual %h", want.out_c, o_result.out_c);
                    failed = 1'b1;
                end
                if (o_result.adj_ca !== want.adj_ca) begin
                    $error("adj_ca expected %h actual %h", want.adj_ca, o_result.adj_ca);
                    failed = 1'b1;
                end
                if (o_result.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_result.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // present one item after a random gap, hold it until taken
    task automatic send_item(t_cmd_item it, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= it;
        do @(posedge i_clk); while (busy);
        predict_item(it);
    endtask

    task automatic load_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit no_gap = 1'b0);
        t_cmd_item it;
        it = '0;
        it.command = CMD_LOAD;
        it.vert_a = a; it.vert_b = b; it.vert_c = c;
        it.tri_select = 10'($urandom());
        send_item(it, no_gap);
    endtask

    task automatic read_tri(logic [9:0] sel);
        t_cmd_item it;
        it = '0;
        it.command = CMD_READ;
        it.tri_select = sel;
        it.vert_a = 16'($urandom()); it.vert_b = 16'($urandom()); it.vert_c = 16'($urandom());
        send_item(it);
    endtask

    task automatic clear_store();
        t_cmd_item it;
        it = '0;
        it.command = CMD_CLEAR;
        send_item(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // extremes, shared edges in both orientations, degenerate and ignored items
    task automatic test_directed();
        t_cmd_item it;
        read_tri(10'd0);
        load_tri(16'h0000, 16'hFFFF, 16'h1234);
        load_tri(16'hFFFF, 16'h0000, 16'hABCD);
        load_tri(16'h1234, 16'hFFFF, 16'h5555);
        load_tri(16'h0000, 16'h1234, 16'hAAAA);
        load_tri(16'h0007, 16'h0007, 16'h0009);
        load_tri(16'h0007, 16'h0009, 16'h0007);
        load_tri(16'h0007, 16'h0007, 16'h0007);
        for (int k = 0; k < 8; k++) read_tri(k[9:0]);
        read_tri(10'h3FF);
        it = '0;
        it.command = CMD_UNUSED;
        it.vert_a = 16'hFFFF; it.vert_b = 16'hFFFF; it.vert_c = 16'hFFFF;
        it.tri_select = 10'h3FF;
        send_item(it);
        read_tri(10'd1);
        clear_store();
        read_tri(10'd0);
    endtask

    // fill to capacity, drop further loads, empty again without a full build
    task automatic test_overflow();
        clear_store();
        for (int k = 0; k < CAP; k++)
            load_tri(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1);
        load_tri(16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_tri(16'h0000, 16'h0000, 16'h0000);
        clear_store();
        load_tri(16'h0001, 16'h0002, 16'h0003);
        load_tri(16'h0002, 16'h0001, 16'h0004);
        read_tri(10'd0);
        read_tri(10'd1);
        read_tri(10'd2);
    endtask

    // sender holds off until every result is back
    task automatic test_pressure();
        load_tri(16'h0003, 16'h0002, 16'h0005);
        read_tri(10'd2);
        wait_drained();
        read_tri(10'd1);
        wait_drained();
        read_tri(10'd2);
    endtask

    task automatic refresh_pool();
        for (int k = 0; k < 16; k++) vert_pool[k] = 16'($urandom());
        vert_pool[0] = 16'h0000;
        vert_pool[1] = 16'hFFFF;
    endtask

    // random meshes that share edges, with some unrelated triangles and noise
    task automatic test_random(int unsigned n_items);
        int unsigned sent, mesh_cap, pick, src;
        logic [15:0] a, b, c;
        t_cmd_item it;
        sent = 0;
        mesh_cap = $urandom_range(2, 30);
        clear_store();
        refresh_pool();
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (mesh_count >= mesh_cap || pick < 3) begin
                clear_store();
                refresh_pool();
                mesh_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(2, 20);
                sent++;
            end else if (pick < 55) begin
                c = vert_pool[$urandom_range(0, 15)];
                if (mesh_count > 0 && $urandom_range(0, 4) != 0) begin
                    // reuse an edge of a stored triangle, reversed or not
                    src = $urandom_range(0, mesh_count - 1);
                    case ($urandom_range(0, 2))
                        0: begin a = mesh_vert[src][0]; b = mesh_vert[src][1]; end
                        1: begin a = mesh_vert[src][1]; b = mesh_vert[src][2]; end
                        default: begin a = mesh_vert[src][2]; b = mesh_vert[src][0]; end
                    endcase
                    case ($urandom_range(0, 5))
                        0: load_tri(a, b, c);
                        1: load_tri(b, a, c);
                        2: load_tri(c, a, b);
                        3: load_tri(c, b, a);
                        4: load_tri(a, c, b);
                        default: load_tri(b, c, a);
                    endcase
                end else begin
                    load_tri(vert_pool[$urandom_range(0, 15)],
                             vert_pool[$urandom_range(0, 15)], 16'($urandom()));
                end
                sent++;
            end else if (pick < 95) begin
                if (mesh_count > 0 && $urandom_range(0, 7) != 0)
                    read_tri(10'($urandom_range(0, mesh_count - 1)));
                else
                    read_tri(10'($urandom()));
                sent++;
            end else begin
                it = '0;
                it.command = CMD_UNUSED;
                it.tri_select = 10'($urandom());
                it.vert_a = 16'($urandom()); it.vert_b = 16'($urandom());
                it.vert_c = 16'($urandom());
                send_item(it);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pressure();
        test_overflow();
        test_random(800);
        wait_drained();
        while (busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* triangle_adjacency_builder_unit.f */
+incdir+hw/rtl
hw/rtl/tab_pkg.sv
hw/rtl/tab_ram.sv
hw/rtl/triangle_adjacency_builder_unit.sv
test/testbench.sv
